### src/qbp_pkg.sv
// Shared types and constants for the quantizing bit packer.
package qbp_pkg;

    // Signed Q24.24 sample and bound width
    localparam int FIX_W = 48;
    // Width of the shared adder: sign-extended operands with headroom
    localparam int ALU_W = FIX_W + 2;
    // Widest code ever produced (four bytes per item at most)
    localparam int HARD_WIDTH_LIMIT = 25;
    localparam int CODE_W = HARD_WIDTH_LIMIT;
    localparam int WIDTH_W = 5;

    // Stream payload widths
    localparam int IN_DATA_W = 152;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = 3;

    // Bit packer byte accumulator
    localparam int ACC_W = 32;
    localparam int ACC_CNT_W = 6;
    localparam int FRAME_CNT_W = 10;
    localparam int POS_W = 9;

    typedef enum logic [3:0] {
        Q_IDLE,
        Q_CMP,
        Q_CLAMP_LO,
        Q_CLAMP_HI,
        Q_NUM,
        Q_DEN,
        Q_DIV,
        Q_FIX,
        Q_ADDDEN,
        Q_ROUND,
        Q_DONE
    } quant_state_t;

    typedef enum logic [1:0] {
        P_IDLE,
        P_QUANT,
        P_EMIT
    } pack_state_t;

endpackage

### src/qbp_quant.sv
// Linear quantizer: clamp, scale and round over one shared adder, one quotient bit a cycle.
module qbp_quant
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [qbp_pkg::FIX_W-1:0]      value,
    input  logic [qbp_pkg::FIX_W-1:0]      range_min,
    input  logic [qbp_pkg::FIX_W-1:0]      range_max,
    input  logic [qbp_pkg::WIDTH_W-1:0]    code_width,
    output logic                           done,
    output logic [qbp_pkg::CODE_W-1:0]     code
);
    import qbp_pkg::*;

    quant_state_t          state_reg, state_next;
    logic [FIX_W-1:0]      num_reg, num_next;   // clamped sample, then value - min
    logic [FIX_W-1:0]      den_reg, den_next;
    logic [FIX_W:0]        r_reg, r_next;       // partial remainder
    logic [CODE_W:0]       q_reg, q_next;       // quotient, one spare bit for the round step
    logic [WIDTH_W-1:0]    cnt_reg, cnt_next;
    logic [CODE_W-1:0]     code_reg, code_next;

    logic [ALU_W-1:0]      alu_a, alu_b, alu_res;
    logic                  alu_sub;
    logic                  neg, zero;
    logic [FIX_W:0]        r_sh;
    logic [CODE_W-1:0]     full;

    assign r_sh = {r_reg[FIX_W-1:0], 1'b0};
    assign full = CODE_W'(((CODE_W+1)'(1) << code_width) - (CODE_W+1)'(1));

    // Shared add/subtract unit, operands chosen by the sequencer
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b1;
        unique case (state_reg)
            Q_CMP:
            begin
                alu_a = {{2{range_min[FIX_W-1]}}, range_min};
                alu_b = {{2{range_max[FIX_W-1]}}, range_max};
            end
            Q_CLAMP_LO:
            begin
                alu_a = {{2{value[FIX_W-1]}}, value};
                alu_b = {{2{range_min[FIX_W-1]}}, range_min};
            end
            Q_CLAMP_HI:
            begin
                alu_a = {{2{num_reg[FIX_W-1]}}, num_reg};
                alu_b = {{2{range_max[FIX_W-1]}}, range_max};
            end
            Q_NUM:
            begin
                alu_a = {{2{num_reg[FIX_W-1]}}, num_reg};
                alu_b = {{2{range_min[FIX_W-1]}}, range_min};
            end
            Q_DEN:
            begin
                alu_a = {{2{range_max[FIX_W-1]}}, range_max};
                alu_b = {{2{range_min[FIX_W-1]}}, range_min};
            end
            Q_DIV:
            begin
                alu_a = {1'b0, r_sh};
                alu_b = {2'b00, den_reg};
            end
            Q_FIX:
            begin
                alu_a = {1'b0, r_reg};
                alu_b = {2'b00, num_reg};
            end
            Q_ADDDEN:
            begin
                alu_a   = {1'b0, r_reg};
                alu_b   = {2'b00, den_reg};
                alu_sub = 1'b0;
            end
            Q_ROUND:
            begin
                alu_a = {1'b0, r_sh};
                alu_b = {2'b00, den_reg};
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    assign neg     = alu_res[ALU_W-1];
    assign zero    = (alu_res == '0);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            Q_IDLE:     if (start) state_next = Q_CMP;
            Q_CMP:      state_next = (zero || !neg) ? Q_DONE : Q_CLAMP_LO;
            Q_CLAMP_LO: state_next = Q_CLAMP_HI;
            Q_CLAMP_HI: state_next = Q_NUM;
            Q_NUM:      state_next = Q_DEN;
            Q_DEN:      state_next = Q_DIV;
            Q_DIV:      if (cnt_reg == WIDTH_W'(1)) state_next = Q_FIX;
            Q_FIX:      state_next = neg ? Q_ADDDEN : Q_ROUND;
            Q_ADDDEN:   state_next = Q_FIX;
            Q_ROUND:    state_next = Q_DONE;
            Q_DONE:     state_next = Q_IDLE;
            default:    state_next = Q_IDLE;
        endcase
    end

    // Datapath
    always_comb
    begin
        num_next  = num_reg;
        den_next  = den_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        code_next = code_reg;
        unique case (state_reg)
            Q_CMP:
            begin
                // equal bounds give zero, inverted bounds give all ones
                if (zero)
                    code_next = '0;
                else if (!neg)
                    code_next = full;
            end
            Q_CLAMP_LO:
                num_next = neg ? range_min : value;
            Q_CLAMP_HI:
                if (!neg && !zero) num_next = range_max;
            Q_NUM:
            begin
                num_next = alu_res[FIX_W-1:0];
                r_next   = {1'b0, alu_res[FIX_W-1:0]};
            end
            Q_DEN:
            begin
                den_next = alu_res[FIX_W-1:0];
                q_next   = '0;
                cnt_next = code_width;
            end
            Q_DIV:
            begin
                // restoring division step
                r_next   = neg ? r_sh : alu_res[FIX_W:0];
                q_next   = {q_reg[CODE_W-1:0], !neg};
                cnt_next = cnt_reg - WIDTH_W'(1);
            end
            Q_FIX:
                // remainder of (2^w - 1) * num; borrow goes through Q_ADDDEN
                if (!neg) r_next = alu_res[FIX_W:0];
            Q_ADDDEN:
            begin
                r_next = alu_res[FIX_W:0];
                q_next = q_reg - (CODE_W+1)'(1);
            end
            Q_ROUND:
                // round half up: 2 * rem >= den
                code_next = CODE_W'(q_reg + (CODE_W+1)'(!neg)) & full;
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        done = (state_reg == Q_DONE);
        code = code_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= Q_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        den_reg  <= den_next;
        r_reg    <= r_next;
        q_reg    <= q_next;
        cnt_reg  <= cnt_next;
        code_reg <= code_next;
    end

endmodule

### src/quantizing_bit_packer.sv
// Top level: quantizes each sample and packs the codes MSB-first into frame bytes.
//
// Each input item is clamped into [range_min, range_max], scaled to
// round((2^w - 1) * (value - min) / (max - min)) and appended MSB-first to a
// byte stream; each completed byte leaves as one output item. The quotient is
// found one bit per cycle on a single shared 50-bit adder; an item gives up
// to four output bytes, each sent once the output register is free. Equal or
// inverted bounds skip the division. Items with width 0 or above
// min(MAX_WIDTH, 25) give one rejected item and leave the bit position alone.
// tlast on the input closes the frame, zero-padding a partial byte. The input
// is not ready while an item is in work; a finished byte waits in the output
// register without holding up the next input item.
module quantizing_bit_packer
#(
    parameter int MAX_FRAME_BYTES = 512,
    parameter int MAX_WIDTH       = 24
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // value[47:0], range_min[95:48], range_max[143:96], code_width[148:144], zero[151:149]
    input  logic [qbp_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  logic                              s_axis_tlast,   // end_of_frame
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // data_byte[7:0], byte_position[16:8], zero[23:17]
    output logic [qbp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // last_of_run[0], rejected[1], overflow[2]
    output logic [qbp_pkg::OUT_USER_W-1:0]    m_axis_tuser,
    output logic                              m_axis_tlast,   // frame_done
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready
);
    import qbp_pkg::*;

    localparam int WIDTH_LIMIT = (MAX_WIDTH < HARD_WIDTH_LIMIT) ? MAX_WIDTH : HARD_WIDTH_LIMIT;
    localparam logic [FRAME_CNT_W-1:0] CNT_MAX = '1;

    pack_state_t            state_reg, state_next;
    logic [FIX_W-1:0]       value_reg, min_reg, max_reg;
    logic [WIDTH_W-1:0]     width_reg;
    logic                   eof_reg;
    logic                   rej_reg, rej_next;
    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic [ACC_CNT_W-1:0]   n_reg, n_next;
    logic [6:0]             pend_bits_reg, pend_bits_next;
    logic [2:0]             pend_cnt_reg, pend_cnt_next;
    logic [FRAME_CNT_W-1:0] cnt_reg, cnt_next;

    logic                   out_valid_reg, out_valid_next;
    logic [7:0]             out_byte_reg, out_byte_next;
    logic [POS_W-1:0]       out_pos_reg, out_pos_next;
    logic                   out_last_reg, out_last_next;
    logic                   out_done_reg, out_done_next;
    logic                   out_rej_reg, out_rej_next;
    logic                   out_ovf_reg, out_ovf_next;

    logic                   in_accept;
    logic [WIDTH_W-1:0]     in_width;
    logic                   width_ok;
    logic                   q_start, q_done;
    logic [CODE_W-1:0]      q_code;
    logic                   slot_free;
    logic [ACC_CNT_W-1:0]   n_after;
    logic                   has_byte, has_pad, has_out;
    logic [POS_W-1:0]       cur_pos;
    logic                   cur_ovf;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_width  = s_axis_tdata[3*FIX_W +: WIDTH_W];
    assign width_ok  = (in_width != '0) && (in_width <= WIDTH_W'(WIDTH_LIMIT));
    assign q_start   = in_accept && width_ok;

    assign slot_free = !out_valid_reg || m_axis_tready;
    assign n_after   = n_reg - ACC_CNT_W'(8);
    assign has_byte  = (n_reg >= ACC_CNT_W'(8));
    assign has_pad   = eof_reg && (n_reg != '0);
    assign has_out   = rej_reg || has_byte || has_pad;
    assign cur_pos   = cnt_reg[FRAME_CNT_W-1] ? '1 : cnt_reg[POS_W-1:0];
    assign cur_ovf   = ({1'b0, cnt_reg} >= (FRAME_CNT_W+1)'(MAX_FRAME_BYTES));

    qbp_quant u_quant
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (q_start),
        .value      (value_reg),
        .range_min  (min_reg),
        .range_max  (max_reg),
        .code_width (width_reg),
        .done       (q_done),
        .code       (q_code)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            P_IDLE:
                if (in_accept) state_next = width_ok ? P_QUANT : P_EMIT;
            P_QUANT:
                if (q_done) state_next = P_EMIT;
            P_EMIT:
                if (!has_out) state_next = P_IDLE;
            default:
                state_next = P_IDLE;
        endcase
    end

    // Packing and output register
    always_comb
    begin
        rej_next       = rej_reg;
        acc_next       = acc_reg;
        n_next         = n_reg;
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_byte_next  = out_byte_reg;
        out_pos_next   = out_pos_reg;
        out_last_next  = out_last_reg;
        out_done_next  = out_done_reg;
        out_rej_next   = out_rej_reg;
        out_ovf_next   = out_ovf_reg;
        unique case (state_reg)
            P_IDLE:
            begin
                if (in_accept && !width_ok)
                begin
                    // rejected item: only the pending bits may still be padded
                    rej_next = 1'b1;
                    acc_next = ACC_W'(pend_bits_reg);
                    n_next   = ACC_CNT_W'(pend_cnt_reg);
                end
            end
            P_QUANT:
            begin
                if (q_done)
                begin
                    acc_next = (ACC_W'(pend_bits_reg) << width_reg) | ACC_W'(q_code);
                    n_next   = ACC_CNT_W'(pend_cnt_reg) + ACC_CNT_W'(width_reg);
                end
            end
            P_EMIT:
            begin
                if (!has_out)
                begin
                    // item finished: keep leftover bits or close the frame
                    if (eof_reg)
                    begin
                        pend_bits_next = '0;
                        pend_cnt_next  = '0;
                        cnt_next       = '0;
                    end
                    else
                    begin
                        pend_bits_next = acc_reg[6:0] & 7'((8'd1 << n_reg[2:0]) - 8'd1);
                        pend_cnt_next  = n_reg[2:0];
                    end
                end
                else if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_pos_next   = cur_pos;
                    if (rej_reg)
                    begin
                        rej_next      = 1'b0;
                        out_byte_next = '0;
                        out_rej_next  = 1'b1;
                        out_ovf_next  = 1'b0;
                        out_last_next = !has_pad;
                        out_done_next = !has_pad && eof_reg;
                    end
                    else
                    begin
                        out_rej_next = 1'b0;
                        out_ovf_next = cur_ovf;
                        if (cnt_reg != CNT_MAX) cnt_next = cnt_reg + FRAME_CNT_W'(1);
                        if (has_byte)
                        begin
                            out_byte_next = 8'(acc_reg >> n_after);
                            n_next        = n_after;
                            out_last_next = (n_after < ACC_CNT_W'(8))
                                            && !(eof_reg && (n_after != '0));
                            out_done_next = eof_reg && (n_after == '0);
                        end
                        else
                        begin
                            // zero-pad the partial byte at end of frame
                            out_byte_next = 8'(acc_reg << (ACC_CNT_W'(8) - n_reg));
                            n_next        = '0;
                            out_last_next = 1'b1;
                            out_done_next = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                rej_next = 1'b0;
            end
        endcase
    end

    // Port drive
    always_comb
    begin
        s_axis_tready = (state_reg == P_IDLE);
        m_axis_tvalid = out_valid_reg;
        m_axis_tdata  = {7'b0, out_pos_reg, out_byte_reg};
        m_axis_tuser  = {out_ovf_reg, out_rej_reg, out_last_reg};
        m_axis_tlast  = out_done_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= P_IDLE;
            rej_reg       <= 1'b0;
            n_reg         <= '0;
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rej_reg       <= rej_next;
            n_reg         <= n_next;
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            value_reg <= s_axis_tdata[0 +: FIX_W];
            min_reg   <= s_axis_tdata[FIX_W +: FIX_W];
            max_reg   <= s_axis_tdata[2*FIX_W +: FIX_W];
            width_reg <= in_width;
            eof_reg   <= s_axis_tlast;
        end
        acc_reg      <= acc_next;
        out_byte_reg <= out_byte_next;
        out_pos_reg  <= out_pos_next;
        out_last_reg <= out_last_next;
        out_done_reg <= out_done_next;
        out_rej_reg  <= out_rej_next;
        out_ovf_reg  <= out_ovf_next;
    end

endmodule

### bench/quantizing_bit_packer_test.sv
// Self-checking stream testbench for the quantizing bit packer.
`timescale 1ns / 1ps

module quantizing_bit_packer_test;

    import qbp_pkg::*;

    localparam int FRAME_LIMIT = 512;
    localparam int CODE_MAX    = 24;
    // Longest quiet stretch: sender gap + the work on one item + a long receiver stall
    localparam int QUIET_LIMIT = 4000;
    localparam int LONG_FRAME  = 200;
    localparam int RAND_ITEMS  = 140;

    localparam logic signed [47:0] FIX_MAX     = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] FIX_MIN     = 48'sh8000_0000_0000;
    localparam logic signed [47:0] FIX_ONE     = 48'sh0000_0100_0000;
    localparam logic signed [47:0] FIX_NEG_ONE = 48'shFFFF_FF00_0000;
    localparam longint             FIX_MAX_L   = 64'sd140737488355327;

    // One output byte as seen on the master side
    typedef struct packed {
        logic [7:0] data_byte;
        logic [8:0] pos;
        logic       last;
        logic       done;
        logic       rej;
        logic       ovf;
    } result_t;

    // One input sample; want is used only on rows with a typed-in result
    typedef struct packed {
        logic signed [47:0] value;
        logic signed [47:0] range_lo;
        logic signed [47:0] range_hi;
        logic [4:0]         width;
        logic               eof;
        logic               typed;
        result_t            want;
    } stim_row_t;

    localparam result_t NO_RES = '0;

    // Directed rows, walked in order right after reset
    localparam stim_row_t DIRECTED [22] = '{
        // bad widths: zero, one above the limit, the top code
        '{48'sd0, 48'sd0, FIX_ONE, 5'd0, 1'b0, 1'b1, '{8'h00, 9'd0, 1'b1, 1'b0, 1'b1, 1'b0}},
        '{48'sd0, 48'sd0, FIX_ONE, 5'd25, 1'b0, 1'b1, '{8'h00, 9'd0, 1'b1, 1'b0, 1'b1, 1'b0}},
        '{FIX_MAX, FIX_MIN, FIX_MAX, 5'd31, 1'b0, 1'b1, '{8'h00, 9'd0, 1'b1, 1'b0, 1'b1, 1'b0}},
        // full-scale range, both ends
        '{FIX_MAX, FIX_MIN, FIX_MAX, 5'd8, 1'b0, 1'b1, '{8'hFF, 9'd0, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{FIX_MIN, FIX_MIN, FIX_MAX, 5'd8, 1'b0, 1'b1, '{8'h00, 9'd1, 1'b1, 1'b0, 1'b0, 1'b0}},
        // equal bounds, then inverted bounds
        '{48'sd0, FIX_ONE, FIX_ONE, 5'd8, 1'b0, 1'b1, '{8'h00, 9'd2, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{48'sd0, FIX_ONE, FIX_NEG_ONE, 5'd8, 1'b0, 1'b1, '{8'hFF, 9'd3, 1'b1, 1'b0, 1'b0, 1'b0}},
        // midpoint, rounds half up
        '{48'sd0, FIX_NEG_ONE, FIX_ONE, 5'd24, 1'b0, 1'b0, NO_RES},
        // clamp low and high, partial bytes
        '{FIX_MIN, FIX_NEG_ONE, FIX_ONE, 5'd1, 1'b0, 1'b0, NO_RES},
        '{FIX_MAX, 48'sd0, FIX_ONE, 5'd3, 1'b0, 1'b0, NO_RES},
        '{48'sd1, 48'sd0, 48'sd3, 5'd4, 1'b0, 1'b0, NO_RES},
        // end of frame with pad
        '{48'sd2, 48'sd0, 48'sd3, 5'd5, 1'b1, 1'b0, NO_RES},
        // end of frame already aligned
        '{FIX_MAX, FIX_MIN, FIX_MAX, 5'd8, 1'b1, 1'b1, '{8'hFF, 9'd0, 1'b1, 1'b1, 1'b0, 1'b0}},
        // bad width closing a frame with and without pending bits
        '{FIX_MAX, 48'sd0, FIX_ONE, 5'd3, 1'b0, 1'b0, NO_RES},
        '{48'sd0, 48'sd0, FIX_ONE, 5'd0, 1'b1, 1'b0, NO_RES},
        '{48'sd0, 48'sd0, FIX_ONE, 5'd0, 1'b1, 1'b1, '{8'h00, 9'd0, 1'b1, 1'b1, 1'b1, 1'b0}},
        // widest code: full scale, inverted, mid
        '{FIX_MAX, FIX_MIN, FIX_MAX, 5'd24, 1'b0, 1'b0, NO_RES},
        '{FIX_MIN, FIX_MAX, FIX_MIN, 5'd24, 1'b0, 1'b0, NO_RES},
        '{48'sd0, FIX_MIN, FIX_MAX, 5'd24, 1'b0, 1'b0, NO_RES},
        // seven pending bits, then a wide code with close: four bytes from one item
        '{48'sd1, 48'sd0, 48'sd2, 5'd7, 1'b0, 1'b0, NO_RES},
        '{48'sd5, 48'sd0, 48'sd7, 5'd24, 1'b1, 1'b0, NO_RES},
        // single bit closing a fresh frame
        '{FIX_ONE, 48'sd0, FIX_ONE, 5'd1, 1'b1, 1'b1, '{8'h80, 9'd0, 1'b1, 1'b1, 1'b0, 1'b0}}
    };

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;

    // Predicted bytes not yet seen, oldest first
    result_t bytes_due [$];
    // Bytes predicted for the item just accepted
    result_t item_bytes [$];

    // Packer state mirror
    logic [31:0] pend_acc = '0;
    int          pend_cnt = 0;
    int          frame_bytes = 0;

    int mismatches = 0;
    int burst_left = 4;
    int quiet_cycles = 0;
    int sink_mode = 0;
    int sink_left = 0;
    int tick = 0;

    quantizing_bit_packer #(
        .MAX_FRAME_BYTES (FRAME_LIMIT),
        .MAX_WIDTH       (CODE_MAX)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Clamp, scale and round half up; long division gives num * 2^w = q * den + r
    function automatic logic [24:0] quant_code(logic signed [47:0] value,
                                               logic signed [47:0] lo,
                                               logic signed [47:0] hi, int w);
        longint          v, l, h;
        longint unsigned num, den, rem, q, full;
        int              i;
        full = (64'd1 << w) - 64'd1;
        v = value;
        l = lo;
        h = hi;
        if (l == h)
            return '0;
        if (l > h)
            return full[24:0];
        if (v < l)
            v = l;
        if (v > h)
            v = h;
        num = v - l;
        den = h - l;
        rem = num;
        q = 0;
        for (i = 0; i < w; i++)
        begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                q = q | 64'd1;
            end
        end
        // remove one num to get (2^w - 1) * num
        if (rem < num)
        begin
            q = q - 64'd1;
            rem = rem + den - num;
        end
        else
            rem = rem - num;
        if (2 * rem >= den)
            q = q + 64'd1;
        return q[24:0] & full[24:0];
    endfunction

    // One completed byte at the current frame position
    task automatic emit_byte(logic [7:0] b);
        result_t r;
        r = '0;
        r.data_byte = b;
        r.pos = (frame_bytes > 511) ? 9'd511 : 9'(frame_bytes);
        r.ovf = (frame_bytes >= FRAME_LIMIT);
        item_bytes.push_back(r);
        if (frame_bytes < 1023)
            frame_bytes++;
    endtask

    // Bytes caused by one accepted item; updates the packer mirror
    task automatic pack_item(stim_row_t row);
        result_t     r;
        logic [31:0] acc;
        int          n;
        item_bytes.delete();
        if (row.width == 0 || row.width > CODE_MAX || row.width > HARD_WIDTH_LIMIT)
        begin
            r = '0;
            r.pos = (frame_bytes > 511) ? 9'd511 : 9'(frame_bytes);
            r.rej = 1'b1;
            item_bytes.push_back(r);
        end
        else
        begin
            acc = (pend_acc << row.width)
                | 32'(quant_code(row.value, row.range_lo, row.range_hi, row.width));
            n = pend_cnt + row.width;
            while (n >= 8)
            begin
                emit_byte(8'(acc >> (n - 8)));
                n -= 8;
            end
            pend_acc = acc & ((32'd1 << n) - 32'd1);
            pend_cnt = n;
        end
        // close the frame, zero-padding any partial byte
        if (row.eof)
        begin
            if (pend_cnt > 0)
                emit_byte(8'(pend_acc << (8 - pend_cnt)));
            pend_acc = '0;
            pend_cnt = 0;
            frame_bytes = 0;
        end
        if (item_bytes.size() > 0)
        begin
            r = item_bytes.pop_back();
            r.last = 1'b1;
            r.done = row.eof;
            item_bytes.push_back(r);
        end
    endtask

    function automatic logic signed [47:0] rand_fix();
        case ($urandom_range(0, 7))
            0: return FIX_MAX;
            1: return FIX_MIN;
            2: return 48'sd0;
            3: return 48'($signed($urandom_range(0, 4000)) - 2000);
            default: return 48'({$urandom, $urandom});
        endcase
    endfunction

    // Random sample; mostly ordered bounds with the value inside
    function automatic stim_row_t rand_item(int wlo, int whi, bit allow_bad, bit eof);
        stim_row_t       row;
        longint          a, b, t;
        longint unsigned off;
        row = '0;
        a = rand_fix();
        b = rand_fix();
        case ($urandom_range(0, 19))
            0: b = a;
            1:
            begin
                if (a < b)
                begin
                    t = a;
                    a = b;
                    b = t;
                end
            end
            2, 3, 4, 5:
            begin
                // tiny span, stresses the rounding
                if (a > FIX_MAX_L - 8)
                    a = a - 8;
                b = a + $urandom_range(1, 6);
            end
            default:
            begin
                if (a > b)
                begin
                    t = a;
                    a = b;
                    b = t;
                end
            end
        endcase
        row.range_lo = 48'(a);
        row.range_hi = 48'(b);
        if (a < b && $urandom_range(0, 9) < 6)
        begin
            off = {$urandom, $urandom};
            t = b - a + 1;
            row.value = 48'(a + longint'(off % longint'(t)));
        end
        else
            row.value = rand_fix();
        if (allow_bad && $urandom_range(0, 9) == 0)
            row.width = ($urandom_range(0, 2) == 0) ? 5'd0 : 5'($urandom_range(CODE_MAX + 1, 31));
        else
            row.width = 5'($urandom_range(wlo, whi));
        row.eof = eof;
        return row;
    endfunction

    task automatic report(string what, result_t want, result_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%s: want byte %02h pos %0d last %b done %b rej %b ovf %b",
                     what, want.data_byte, want.pos, want.last, want.done, want.rej, want.ovf);
            $display("    got byte %02h pos %0d last %b done %b rej %b ovf %b",
                     got.data_byte, got.pos, got.last, got.done, got.rej, got.ovf);
        end
    endtask

    // Present one item, hold until taken, then predict; bursts with random gaps
    task automatic send_item(stim_row_t row);
        int gap;
        int k;
        s_axis_tdata  <= {3'b000, row.width, row.range_hi, row.range_lo, row.value};
        s_axis_tlast  <= row.eof;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        pack_item(row);
        if (row.typed)
            bytes_due.push_back(row.want);
        else
            for (k = 0; k < item_bytes.size(); k++)
                bytes_due.push_back(item_bytes[k]);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Hold off the sender until every predicted byte has arrived
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (bytes_due.size() != 0);
    endtask

    // Receiver: switches among always ready, random, fixed duty and mostly stalled
    always @(posedge clk)
    begin
        tick <= tick + 1;
        if (sink_left == 0)
        begin
            sink_mode <= $urandom_range(0, 3);
            sink_left <= $urandom_range(20, 200);
        end
        else
            sink_left <= sink_left - 1;
        case (sink_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: m_axis_tready <= ((tick % 9) >= 5);
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Compare each byte taken with the oldest prediction
    always @(posedge clk)
    begin
        result_t seen;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen = '{m_axis_tdata[7:0], m_axis_tdata[16:8], m_axis_tuser[0],
                     m_axis_tlast, m_axis_tuser[1], m_axis_tuser[2]};
            if (bytes_due.size() == 0)
                report("unexpected byte", NO_RES, seen);
            else
            begin
                want = bytes_due.pop_front();
                if (want !== seen)
                    report("byte mismatch", want, seen);
            end
        end
    end

    // Watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("stalled for %0d cycles", quiet_cycles);
            $display("quantizing_bit_packer_test: errors");
            $finish;
        end
    end

    initial
    begin
        int        k;
        int        sent;
        int        flen;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < 22; k++)
            send_item(DIRECTED[k]);
        wait_drained();

        // one long frame of wide codes runs past the frame limit
        for (k = 0; k < LONG_FRAME; k++)
            send_item(rand_item(22, CODE_MAX, 1'b0, k == LONG_FRAME - 1));
        wait_drained();

        // short frames of random content
        sent = 0;
        while (sent < RAND_ITEMS)
        begin
            flen = $urandom_range(1, 10);
            for (k = 0; k < flen; k++)
                send_item(rand_item(1, CODE_MAX, 1'b1, k == flen - 1));
            sent += flen;
            if ($urandom_range(0, 15) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (64) @(posedge clk);
        while (bytes_due.size() != 0)
            report("missing byte", bytes_due.pop_front(), NO_RES);
        if (mismatches == 0)
            $display("quantizing_bit_packer_test: clean");
        else
            $display("quantizing_bit_packer_test: errors");
        $finish;
    end

endmodule

### quantizing_bit_packer.f
src/qbp_pkg.sv
src/qbp_quant.sv
src/quantizing_bit_packer.sv
bench/quantizing_bit_packer_test.sv
